### src/cartridge_bank_mapper_irq_macros.svh
// assertion helpers for the bank mapper
`ifndef CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH
`define CARTRIDGE_BANK_MAPPER_IRQ_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CBM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CBM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/cbm_pkg.sv
`default_nettype none
package cbm_pkg;

	// opcodes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_PPU   = 2'd3;

	// result kinds
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_REG  = 3'd1;
	localparam logic [2:0] KIND_PRG  = 3'd2;
	localparam logic [2:0] KIND_WRAM = 3'd3;
	localparam logic [2:0] KIND_CHR  = 3'd4;
	localparam logic [2:0] KIND_NT   = 3'd5;

	// config register indexes
	localparam logic [1:0] CFG_VARIANT   = 2'd0;
	localparam logic [1:0] CFG_SUBMAPPER = 2'd1;
	localparam logic [1:0] CFG_DIPSWITCH = 2'd2;

	// register groups above 0x8000
	localparam logic [1:0] GRP_OUTER = 2'd0;
	localparam logic [1:0] GRP_MODE  = 2'd1;
	localparam logic [1:0] GRP_IRQ   = 2'd2;
	localparam logic [1:0] GRP_BANK  = 2'd3;

	// CHR modes
	localparam logic [1:0] CHR_2K    = 2'd1;
	localparam logic [1:0] CHR_OUTER = 2'd2;

	// WRAM-enabling submapper
	localparam logic [1:0] SUB_WRAM = 2'd2;

	// nametable arrangements
	localparam logic [1:0] NT_VERT   = 2'd0;
	localparam logic [1:0] NT_HORZ   = 2'd1;
	localparam logic [1:0] NT_SINGLE0 = 2'd2;

	// address pages
	localparam logic [3:0] PAGE_SCRATCH = 4'h5;
	localparam logic [1:0] WIN_WRAM     = 2'b11;

	// PRG masks
	localparam logic [4:0] PRG_MASK_83  = 5'h1F;
	localparam logic [4:0] PRG_MASK_264 = 5'h0F;

	localparam logic [7:0] MODE_RST = 8'h10;
	localparam logic [3:0][7:0] PRG_RST = {8'hFF, 8'hFE, 8'hFD, 8'hFC};
	localparam logic [7:0][7:0] CHR_RST = {8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};

	typedef struct packed {
		logic       variant;
		logic [1:0] submapper;
		logic [7:0] dipswitch;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] addr;
		logic [7:0]  wdata;
	} item_t;

	typedef struct packed {
		logic [7:0]      mode;
		logic [7:0]      outer;
		logic [3:0][7:0] scratch;
		logic [3:0][7:0] prg;
		logic [7:0][7:0] chr;
		logic            irq_en;
		logic [15:0]     irq_cnt;
		logic            irq_raised;
	} map_state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic [9:0] bank;
		logic       irq;
	} result_t;

endpackage
`default_nettype wire

### src/cartridge_bank_mapper_irq.sv
// Bank-switching cartridge mapper with a 16-bit CPU-cycle IRQ counter. Each beat
// on the input channel is a CPU write, CPU read, CPU cycle tick or PPU lookup, and
// gives exactly one result beat: the kind of window, a register byte or a bank
// number, and the IRQ line as it stands after the beat. One beat is taken every
// cycle unless a held result is stalled at the output; beats pass an input and a
// result register, with the whole register update and address translation done
// in the single pass between them. The user must write configuration (variant,
// submapper, dipswitch byte) only when no beat is in flight; nothing enforces it.
`default_nettype none
module cartridge_bank_mapper_irq (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_write_en,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  opcode,
	input  wire logic [15:0] bus_address,
	input  wire logic [7:0]  write_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       result_kind,
	output logic [7:0]       read_data,
	output logic [9:0]       bank_number,
	output logic             irq_line
);

	`include "cartridge_bank_mapper_irq_macros.svh"

	cbm_pkg::cfg_t       cfg_q;
	cbm_pkg::item_t      item_s1;
	logic                valid_s1;
	cbm_pkg::result_t    res_s2;
	logic                valid_s2;
	logic                adv;
	cbm_pkg::map_state_t st;
	logic                irq_next;
	logic [2:0]          kind;
	logic [7:0]          data;
	logic [9:0]          bank;

	assign adv      = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				cbm_pkg::CFG_VARIANT:   cfg_q.variant   <= cfg_data[0];
				cbm_pkg::CFG_SUBMAPPER: cfg_q.submapper <= cfg_data[1:0];
				cbm_pkg::CFG_DIPSWITCH: cfg_q.dipswitch <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= '{opcode: opcode, addr: bus_address, wdata: write_value};
		if (adv)
			res_s2 <= '{kind: kind, data: data, bank: bank, irq: irq_next};
	end

	cbm_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item     (item_s1),
		.variant  (cfg_q.variant),
		.st       (st),
		.irq_next (irq_next)
	);

	cbm_translate u_translate (
		.cfg  (cfg_q),
		.st   (st),
		.item (item_s1),
		.kind (kind),
		.data (data),
		.bank (bank)
	);

	assign out_valid   = valid_s2;
	assign result_kind = res_s2.kind;
	assign read_data   = res_s2.data;
	assign bank_number = res_s2.bank;
	assign irq_line    = res_s2.irq;

	`CBM_ASSERT_IMPL(a_stall_held, in_stall, valid_s1, "input stalled with no held beat")
	`CBM_ASSERT_IMPL(a_data_kind, valid_s2 && res_s2.kind != cbm_pkg::KIND_REG, res_s2.data == 8'd0, "read data outside register read")
	`CBM_ASSERT_IMPL(a_bank_none, valid_s2 && res_s2.kind == cbm_pkg::KIND_NONE, res_s2.bank == 10'd0, "bank set on empty result")
	`CBM_ASSERT_NEXT(a_cnt_hold, !adv, $stable(st.irq_cnt), "irq counter moved without a beat")

endmodule
`default_nettype wire

### src/cbm_state.sv
`default_nettype none
module cbm_state (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire cbm_pkg::item_t     item,
	input  wire logic               variant,
	output cbm_pkg::map_state_t     st,
	output logic                    irq_next
);

	cbm_pkg::map_state_t st_q;
	cbm_pkg::map_state_t nxt;
	logic [1:0]  grp;
	logic [15:0] cnt_step;

	assign grp      = variant ? item.addr[11:10] : item.addr[9:8];
	assign cnt_step = st_q.mode[6] ? (st_q.irq_cnt - 16'd1) : (st_q.irq_cnt + 16'd1);

	always_comb begin
		nxt = st_q;
		if (adv) begin
			unique case (item.opcode)
				cbm_pkg::OP_WRITE: begin
					if (item.addr[15:12] == cbm_pkg::PAGE_SCRATCH) begin
						nxt.scratch[item.addr[1:0]] = item.wdata;
					end else if (item.addr[15]) begin
						unique case (grp)
							cbm_pkg::GRP_OUTER: nxt.outer = item.wdata;
							cbm_pkg::GRP_MODE:  nxt.mode  = item.wdata;
							cbm_pkg::GRP_IRQ: begin
								if (item.addr[0]) begin
									nxt.irq_en        = st_q.mode[7];
									nxt.irq_cnt[15:8] = item.wdata;
								end else begin
									nxt.irq_cnt[7:0] = item.wdata;
									nxt.irq_raised   = 1'b0;
								end
							end
							cbm_pkg::GRP_BANK: begin
								if (!item.addr[4])
									nxt.prg[item.addr[1:0]] = item.wdata;
								else if (!item.addr[3])
									nxt.chr[item.addr[2:0]] = item.wdata;
							end
							default: ;
						endcase
					end
				end
				cbm_pkg::OP_TICK: begin
					if (st_q.irq_en && st_q.irq_cnt != 16'd0) begin
						nxt.irq_cnt = cnt_step;
						if (cnt_step == 16'd0) begin
							nxt.irq_raised = 1'b1;
							nxt.irq_en     = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode       <= cbm_pkg::MODE_RST;
			st_q.outer      <= '0;
			st_q.scratch    <= '0;
			st_q.prg        <= cbm_pkg::PRG_RST;
			st_q.chr        <= cbm_pkg::CHR_RST;
			st_q.irq_en     <= 1'b0;
			st_q.irq_cnt    <= '0;
			st_q.irq_raised <= 1'b0;
		end else begin
			st_q <= nxt;
		end
	end

	assign st       = st_q;
	assign irq_next = nxt.irq_raised;

endmodule
`default_nettype wire

### src/cbm_translate.sv
`default_nettype none
module cbm_translate (
	input  wire cbm_pkg::cfg_t       cfg,
	input  wire cbm_pkg::map_state_t st,
	input  wire cbm_pkg::item_t      item,
	output logic [2:0]               kind,
	output logic [7:0]               data,
	output logic [9:0]               bank
);

	logic [4:0] m;
	logic [1:0] slot;
	logic [9:0] prg_bank;
	logic [9:0] prg_base;
	logic [9:0] prg_low;
	logic [2:0] cslot;
	logic [2:0] pick;
	logic [1:0] cm;
	logic [9:0] chr_bank;
	logic       nt_page;
	logic       sel;

	assign m     = cfg.variant ? cbm_pkg::PRG_MASK_264 : cbm_pkg::PRG_MASK_83;
	assign slot  = item.addr[14:13];
	assign cslot = item.addr[12:10];
	assign pick  = {item.addr[12], item.addr[12], item.addr[11]};
	assign cm    = cfg.variant ? cbm_pkg::CHR_2K : cfg.submapper;
	assign sel   = cfg.variant ? item.addr[10] : item.addr[8];

	assign prg_base = {1'b0, st.outer, 1'b0} & ~{5'b0, m};
	assign prg_low  = (slot == 2'd3) ? {5'b0, m} : {5'b0, st.prg[slot][4:0] & m};

	always_comb begin
		case (st.mode[4:3])
			2'b00: begin
				if (!slot[1])
					prg_bank = {1'b0, st.outer, slot[0]};
				else
					prg_bank = {1'b0, st.outer | {4'h0, m[4:1]}, slot[0]};
			end
			2'b01:   prg_bank = {1'b0, st.outer[7:1], slot};
			default: prg_bank = prg_base | prg_low;
		endcase
	end

	always_comb begin
		case (cm)
			cbm_pkg::CHR_2K:    chr_bank = {1'b0, st.chr[pick], item.addr[10]};
			cbm_pkg::CHR_OUTER: chr_bank = {st.outer[5:4], st.chr[cslot]};
			default:            chr_bank = {2'b0, st.chr[cslot]};
		endcase
	end

	always_comb begin
		case (st.mode[1:0])
			cbm_pkg::NT_VERT:    nt_page = item.addr[10];
			cbm_pkg::NT_HORZ:    nt_page = item.addr[11];
			cbm_pkg::NT_SINGLE0: nt_page = 1'b0;
			default:             nt_page = 1'b1;
		endcase
	end

	always_comb begin
		kind = cbm_pkg::KIND_NONE;
		data = '0;
		bank = '0;
		unique case (item.opcode)
			cbm_pkg::OP_READ: begin
				if (item.addr[15:12] == cbm_pkg::PAGE_SCRATCH) begin
					kind = cbm_pkg::KIND_REG;
					data = sel ? st.scratch[item.addr[1:0]] : cfg.dipswitch;
				end else if (item.addr[15]) begin
					kind = cbm_pkg::KIND_PRG;
					bank = prg_bank;
				end else if (item.addr[14:13] == cbm_pkg::WIN_WRAM) begin
					if (!cfg.variant && cfg.submapper == cbm_pkg::SUB_WRAM) begin
						kind = cbm_pkg::KIND_WRAM;
					end else if (st.mode[5]) begin
						kind = cbm_pkg::KIND_PRG;
						bank = {2'b0, st.prg[3]};
					end
				end
			end
			cbm_pkg::OP_PPU: begin
				if (!item.addr[13]) begin
					kind = cbm_pkg::KIND_CHR;
					bank = chr_bank;
				end else begin
					kind = cbm_pkg::KIND_NT;
					bank = {9'b0, nt_page};
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

### dv/cartridge_bank_mapper_irq_tb.sv
`timescale 1ns / 1ps
module cartridge_bank_mapper_irq_tb;
	import cbm_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RANDOM_PER_PHASE = 155;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_write_en = 1'b0;
	logic [1:0]  cfg_index = CFG_VARIANT;
	logic [7:0]  cfg_data = 8'h00;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode = OP_WRITE;
	logic [15:0] bus_address = 16'h0000;
	logic [7:0]  write_value = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  result_kind;
	logic [7:0]  read_data;
	logic [9:0]  bank_number;
	logic        irq_line;

	cartridge_bank_mapper_irq dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.bus_address(bus_address),
		.write_value(write_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_kind(result_kind),
		.read_data(read_data),
		.bank_number(bank_number),
		.irq_line(irq_line)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	cfg_t        board;
	map_state_t  shadow;
	item_t       pending_beats[$];
	result_t     results_due[$];
	item_t       held;
	int unsigned send_gap = 0;
	int unsigned stall_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	bit          calm = 1'b0;

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatches++;
		$display("%0t mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
	endtask

	function automatic logic [9:0] prg_window(logic [15:0] a);
		logic [4:0] m;
		logic [1:0] slot;
		logic [9:0] outer;
		logic [9:0] tmp;
		m = board.variant ? PRG_MASK_264 : PRG_MASK_83;
		slot = a[14:13];
		outer = {2'b00, shadow.outer};
		case (shadow.mode[4:3])
			2'b00: begin
				tmp = slot[1] ? (outer | {6'd0, m[4:1]}) : outer;
				return {tmp[8:0], slot[0]};
			end
			2'b01: return {outer[8:1], slot};
			default: begin
				tmp = {outer[8:0], 1'b0} & ~{5'd0, m};
				return tmp | {5'd0, (slot == 2'd3) ? m : (shadow.prg[slot][4:0] & m)};
			end
		endcase
	endfunction

	function automatic logic [9:0] chr_window(logic [13:0] p);
		logic [1:0] cmode;
		logic [2:0] pick;
		cmode = board.variant ? CHR_2K : board.submapper;
		// 2K pairs come from registers 0, 1, 6, 7
		pick = {p[12], p[12], p[11]};
		if (cmode == CHR_2K)
			return {1'b0, shadow.chr[pick], p[10]};
		if (cmode == CHR_OUTER)
			return {shadow.outer[5:4], shadow.chr[p[12:10]]};
		return {2'b00, shadow.chr[p[12:10]]};
	endfunction

	function automatic void apply_write(logic [15:0] a, logic [7:0] v);
		logic [15:0] r;
		if (a[15:12] == PAGE_SCRATCH) begin
			shadow.scratch[a[1:0]] = v;
			return;
		end
		if (!a[15])
			return;
		r = board.variant ? (((a & 16'h0F00) >> 2) | (a & 16'h003F)) : a;
		case (r[9:8])
			GRP_OUTER: shadow.outer = v;
			GRP_MODE: shadow.mode = v;
			GRP_IRQ: begin
				if (r[0]) begin
					shadow.irq_en = shadow.mode[7];
					shadow.irq_cnt[15:8] = v;
				end else begin
					shadow.irq_cnt[7:0] = v;
					shadow.irq_raised = 1'b0;
				end
			end
			GRP_BANK: begin
				if (r[4:0] <= 5'h0F)
					shadow.prg[r[1:0]] = v;
				else if (r[4:0] <= 5'h17)
					shadow.chr[r[2:0]] = v;
			end
		endcase
	endfunction

	function automatic result_t translate_access(item_t it);
		result_t r;
		r = '0;
		case (it.opcode)
			OP_WRITE: apply_write(it.addr, it.wdata);
			OP_READ: begin
				if (it.addr[15:12] == PAGE_SCRATCH) begin
					r.kind = KIND_REG;
					r.data = (board.variant ? it.addr[10] : it.addr[8]) ?
						shadow.scratch[it.addr[1:0]] : board.dipswitch;
				end else if (it.addr[15]) begin
					r.kind = KIND_PRG;
					r.bank = prg_window(it.addr);
				end else if (it.addr[14:13] == WIN_WRAM) begin
					if (!board.variant && board.submapper == SUB_WRAM) begin
						r.kind = KIND_WRAM;
					end else if (shadow.mode[5]) begin
						r.kind = KIND_PRG;
						r.bank = {2'b00, shadow.prg[3]};
					end
				end
			end
			OP_TICK: begin
				if (shadow.irq_en && shadow.irq_cnt != 16'd0) begin
					shadow.irq_cnt = shadow.mode[6] ? shadow.irq_cnt - 16'd1 :
						shadow.irq_cnt + 16'd1;
					if (shadow.irq_cnt == 16'd0) begin
						shadow.irq_raised = 1'b1;
						shadow.irq_en = 1'b0;
					end
				end
			end
			OP_PPU: begin
				if (!it.addr[13]) begin
					r.kind = KIND_CHR;
					r.bank = chr_window(it.addr[13:0]);
				end else begin
					r.kind = KIND_NT;
					case (shadow.mode[1:0])
						NT_VERT: r.bank = {9'd0, it.addr[10]};
						NT_HORZ: r.bank = {9'd0, it.addr[11]};
						NT_SINGLE0: r.bank = 10'd0;
						default: r.bank = 10'd1;
					endcase
				end
			end
		endcase
		r.irq = shadow.irq_raised;
		return r;
	endfunction

	// driver: one beat in flight, payload held while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				results_due.push_back(translate_access(held));
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 12);
					in_valid <= 1'b0;
				end else if (pending_beats.size() > 0) begin
					held = pending_beats.pop_front();
					opcode <= held.opcode;
					bus_address <= held.addr;
					write_value <= held.wdata;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					report_mismatch("unexpected beat, kind", 16'(result_kind),
						16'(KIND_NONE));
				end else begin
					want = results_due.pop_front();
					if (result_kind !== want.kind)
						report_mismatch("result_kind", 16'(result_kind), 16'(want.kind));
					if (read_data !== want.data)
						report_mismatch("read_data", 16'(read_data), 16'(want.data));
					if (bank_number !== want.bank)
						report_mismatch("bank_number", 16'(bank_number), 16'(want.bank));
					if (irq_line !== want.irq)
						report_mismatch("irq_line", 16'(irq_line), 16'(want.irq));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 12);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("** cartridge_bank_mapper_irq: FAILED **");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic queue_beat(input logic [1:0] op, input logic [15:0] a, input logic [7:0] v);
		item_t it;
		it.opcode = op;
		it.addr = a;
		it.wdata = v;
		pending_beats.push_back(it);
	endtask

	// address of a register above 0x8000 with don't-care bits randomized
	function automatic logic [15:0] reg_addr(logic [1:0] grp, logic [4:0] idx);
		logic [15:0] a;
		a = 16'($urandom);
		a[15] = 1'b1;
		a[4:0] = idx;
		if (board.variant)
			a[11:10] = grp;
		else
			a[9:8] = grp;
		return a;
	endfunction

	task automatic program_board(input cfg_t c);
		@(posedge clk);
		cfg_write_en <= 1'b1;
		cfg_index <= CFG_VARIANT;
		cfg_data <= {7'd0, c.variant};
		@(posedge clk);
		cfg_index <= CFG_SUBMAPPER;
		cfg_data <= {6'd0, c.submapper};
		@(posedge clk);
		cfg_index <= CFG_DIPSWITCH;
		cfg_data <= c.dipswitch;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		board = c;
	endtask

	task automatic queue_directed();
		queue_beat(OP_READ, 16'h8000, 8'h00);
		queue_beat(OP_READ, 16'hA000, 8'hFF);
		queue_beat(OP_READ, 16'hC000, 8'h00);
		queue_beat(OP_READ, 16'hFFFF, 8'h00);
		queue_beat(OP_READ, 16'h0000, 8'h00);
		queue_beat(OP_READ, 16'h4FFF, 8'h00);
		queue_beat(OP_READ, 16'h6000, 8'h00);
		queue_beat(OP_READ, 16'h7FFF, 8'h00);
		queue_beat(OP_READ, 16'h5000, 8'h00);
		queue_beat(OP_WRITE, 16'h5003, 8'hFF);
		queue_beat(OP_READ, 16'h5103, 8'h00);
		queue_beat(OP_READ, 16'h5FFF, 8'h00);
		queue_beat(OP_PPU, 16'h0000, 8'h00);
		queue_beat(OP_PPU, 16'h1FFF, 8'h00);
		queue_beat(OP_PPU, 16'h2000, 8'h00);
		queue_beat(OP_PPU, 16'h2C00, 8'h00);
		queue_beat(OP_PPU, 16'hFFFF, 8'h00);
		// unused bank slot, then a live CHR slot
		queue_beat(OP_WRITE, reg_addr(GRP_BANK, 5'h18), 8'hAA);
		queue_beat(OP_WRITE, reg_addr(GRP_BANK, 5'h17), 8'h80);
		queue_beat(OP_PPU, 16'h1C00, 8'h00);
		// armed down-counter from 2, runs to zero, then cleared
		queue_beat(OP_WRITE, reg_addr(GRP_MODE, 5'h00), 8'hC3);
		queue_beat(OP_WRITE, reg_addr(GRP_IRQ, 5'h00), 8'h02);
		queue_beat(OP_WRITE, reg_addr(GRP_IRQ, 5'h01), 8'h00);
		repeat (3) queue_beat(OP_TICK, 16'h0000, 8'h00);
		queue_beat(OP_WRITE, reg_addr(GRP_IRQ, 5'h00), 8'h00);
		queue_beat(OP_WRITE, 16'hFFFF, 8'h00);
	endtask

	task automatic queue_random(input int unsigned count);
		int unsigned made;
		int unsigned n;
		logic [15:0] a;
		logic [15:0] cnt;
		logic [7:0]  v;
		logic [4:0]  idx;
		made = 0;
		while (made < count) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					queue_beat(OP_WRITE, reg_addr(2'($urandom_range(0, 3)), 5'($urandom)),
						8'($urandom));
					made++;
				end
				2: begin
					a = 16'($urandom);
					a[15:12] = PAGE_SCRATCH;
					queue_beat(OP_WRITE, a, 8'($urandom));
					made++;
				end
				3, 4: begin
					a = 16'($urandom);
					case ($urandom_range(0, 3))
						0: a = 16'($urandom_range(0, 16'h4FFF));
						1: a[15:12] = PAGE_SCRATCH;
						2: a[15:13] = {1'b0, WIN_WRAM};
						default: a[15] = 1'b1;
					endcase
					queue_beat(OP_READ, a, 8'($urandom));
					made++;
				end
				5: begin
					queue_beat(OP_PPU, 16'($urandom), 8'($urandom));
					made++;
				end
				6: begin
					n = $urandom_range(1, 6);
					repeat (n) queue_beat(OP_TICK, 16'($urandom), 8'($urandom));
					made += n;
				end
				7, 8: begin
					v = 8'($urandom);
					v[7] = ($urandom_range(0, 3) != 0);
					queue_beat(OP_WRITE, reg_addr(GRP_MODE, 5'($urandom)), v);
					n = $urandom_range(1, 6);
					cnt = 16'(n);
					if (!v[6])
						cnt = -cnt;
					if ($urandom_range(0, 7) == 0)
						cnt = 16'($urandom);
					idx = 5'($urandom);
					idx[0] = 1'b0;
					queue_beat(OP_WRITE, reg_addr(GRP_IRQ, idx), cnt[7:0]);
					idx[0] = 1'b1;
					queue_beat(OP_WRITE, reg_addr(GRP_IRQ, idx), cnt[15:8]);
					made += 3;
					repeat (n + $urandom_range(0, 2)) begin
						if ($urandom_range(0, 3) == 0) begin
							queue_beat(OP_PPU, 16'($urandom), 8'($urandom));
							made++;
						end
						queue_beat(OP_TICK, 16'($urandom), 8'($urandom));
						made++;
					end
					if ($urandom_range(0, 1)) begin
						idx[0] = 1'b0;
						queue_beat(OP_WRITE, reg_addr(GRP_IRQ, idx), 8'($urandom));
						made++;
					end
				end
				default: begin
					queue_beat(2'($urandom), 16'($urandom), 8'($urandom));
					made++;
				end
			endcase
		end
	endtask

	initial begin
		cfg_t plan [6];
		plan[0] = {1'b0, 2'd0, 8'h00};
		plan[1] = {1'b0, 2'd1, 8'hFF};
		plan[2] = {1'b1, 2'd0, 8'hA5};
		plan[3] = {1'b0, 2'd2, 8'h5A};
		plan[4] = {1'b1, 2'd2, 8'hFF};
		plan[5] = {1'b0, 2'd0, 8'h3C};
		board = '0;
		shadow = '0;
		shadow.mode = MODE_RST;
		shadow.prg = PRG_RST;
		shadow.chr = CHR_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < 6; p++) begin
			calm = (p == 5);
			program_board(plan[p]);
			if (p == 0)
				queue_directed();
			queue_random(RANDOM_PER_PHASE);
			do @(negedge clk);
			while (pending_beats.size() != 0 || results_due.size() != 0 || in_valid);
			repeat (4) @(posedge clk);
		end
		if (mismatches == 0)
			$display("** cartridge_bank_mapper_irq: PASSED **");
		else
			$display("** cartridge_bank_mapper_irq: FAILED **");
		$finish;
	end

endmodule
